### hw/rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg: shared definitions for the subaperture centroid tracker
// Holds default sizes, fixed field widths, register codes and the types that
// pass between the tracker's front end, request queue and divider back end.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

  // Default sizes, used as parameter defaults on the top level.
  localparam int MAX_WINDOW_DEF       = 64;
  localparam int MAX_SUBAPERTURES_DEF = 1024;
  localparam int PIXEL_BITS_DEF       = 16;

  // Fixed field widths.
  localparam int COG_W      = 16;  // signed centroid, 8 fraction bits
  localparam int FRAC_BITS  = 8;
  localparam int FSUM_W     = 40;  // frame sum wraps at this width
  localparam int REG_SIZE_W = 7;   // width, height and reference registers
  localparam int REG_CNT_W  = 11;  // subaperture count register

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Depth of the request queue between front end and back end.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes (byte address / 4).
  typedef enum logic [2:0] {
    REG_WINDOW_WIDTH  = 3'd0,
    REG_WINDOW_HEIGHT = 3'd1,
    REG_REFERENCE_X   = 3'd2,
    REG_REFERENCE_Y   = 3'd3,
    REG_SUBAP_COUNT   = 3'd4
  } cfg_reg_t;

  // Current configuration as seen by the front end.
  typedef struct packed {
    logic [REG_SIZE_W-1:0] window_width;
    logic [REG_SIZE_W-1:0] window_height;
    logic [REG_SIZE_W-1:0] reference_x;
    logic [REG_SIZE_W-1:0] reference_y;
    logic [REG_CNT_W-1:0]  subaperture_count;
  } cfg_t;

  // Queue fill status.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage : sct_pkg

`default_nettype wire

### hw/rtl/sct_in_if.sv
// ----------------------------------------------------------------------------
// sct_in_if: pixel stream channel
// Valid/ready channel that carries one camera pixel per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface sct_in_if #(
  parameter int PIXEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface : sct_in_if

`default_nettype wire

### hw/rtl/sct_out_if.sv
// ----------------------------------------------------------------------------
// sct_out_if: centroid result channel
// Valid/ready channel that carries one window centroid and frame statistics.
// ----------------------------------------------------------------------------
`default_nettype none

interface sct_out_if #(
  parameter int PIXEL_BITS  = 16,
  parameter int INDEX_BITS  = 10
);
  logic                   valid;
  logic                   ready;
  logic signed [15:0]     cog_x;
  logic signed [15:0]     cog_y;
  logic [INDEX_BITS-1:0]  window_index;
  logic [39:0]            frame_sum;
  logic [PIXEL_BITS-1:0]  frame_max;
  logic                   frame_done;

  modport source (output valid, output cog_x, output cog_y, output window_index,
                  output frame_sum, output frame_max, output frame_done,
                  input ready);
  modport sink   (input valid, input cog_x, input cog_y, input window_index,
                  input frame_sum, input frame_max, input frame_done,
                  output ready);
endinterface : sct_out_if

`default_nettype wire

### hw/rtl/subaperture_centroid_tracker.sv
// ----------------------------------------------------------------------------
// subaperture_centroid_tracker: centre-of-gravity centroiding per window
// Accumulates the pixels of each tracker window and reports its centroid
// together with the frame's running pixel sum and peak.
// ----------------------------------------------------------------------------
// Usage:
// Pixels arrive on in_stream in raster order, one window after another; a
// pixel request is taken whenever valid and ready are both high, at up to
// one pixel per cycle. At the last pixel of each window one result request
// is presented on out_result: reference minus centroid for column and row
// (signed, 8 fraction bits), the window index, frame sum, frame peak and a
// flag on the frame's last window.
// A window end is queued and divided by two restoring dividers at one
// quotient bit per cycle. The front end keeps taking pixels while the back
// end divides; the pixel input stalls only once the two-entry queue is full.
// A stalled receiver holds the result in the output register; the divider
// and queue keep working until both are full, then in_stream.ready drops.
// Reset clears all counters, sums and the queue, and loads the registers
// with width 8, height 8, references 8 and one window per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module subaperture_centroid_tracker import sct_pkg::*; #(
  parameter int MAX_WINDOW       = MAX_WINDOW_DEF,
  parameter int MAX_SUBAPERTURES = MAX_SUBAPERTURES_DEF,
  parameter int PIXEL_BITS       = PIXEL_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sct_in_if.sink                 in_stream,
  sct_out_if.source              out_result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int INDEX_BITS = (MAX_SUBAPERTURES > 1) ? $clog2(MAX_SUBAPERTURES) : 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW);
  localparam int SUM_W      = PIXEL_BITS + 2 * CNT_W;
  localparam int WS_W       = SUM_W + CNT_W;
  localparam int JOB_W      = 2 * WS_W + SUM_W + 2 * REG_SIZE_W + INDEX_BITS
                              + FSUM_W + PIXEL_BITS + 1;

  cfg_t             cfg_r, cfg_nxt;
  cfg_reg_t         reg_sel;
  logic             cfg_wr;
  q_stat_t          q_stat;
  logic             q_push, q_pop;
  logic [JOB_W-1:0] q_push_data, q_pop_data;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = cfg_reg_t'(paddr[4:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_WINDOW_WIDTH:  cfg_nxt.window_width      = pwdata[REG_SIZE_W-1:0];
        REG_WINDOW_HEIGHT: cfg_nxt.window_height     = pwdata[REG_SIZE_W-1:0];
        REG_REFERENCE_X:   cfg_nxt.reference_x       = pwdata[REG_SIZE_W-1:0];
        REG_REFERENCE_Y:   cfg_nxt.reference_y       = pwdata[REG_SIZE_W-1:0];
        REG_SUBAP_COUNT:   cfg_nxt.subaperture_count = pwdata[REG_CNT_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_width      <= REG_SIZE_W'(8);
      cfg_r.window_height     <= REG_SIZE_W'(8);
      cfg_r.reference_x       <= REG_SIZE_W'(8);
      cfg_r.reference_y       <= REG_SIZE_W'(8);
      cfg_r.subaperture_count <= REG_CNT_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_sel)
      REG_WINDOW_WIDTH:  prdata = DATA_W'(cfg_r.window_width);
      REG_WINDOW_HEIGHT: prdata = DATA_W'(cfg_r.window_height);
      REG_REFERENCE_X:   prdata = DATA_W'(cfg_r.reference_x);
      REG_REFERENCE_Y:   prdata = DATA_W'(cfg_r.reference_y);
      REG_SUBAP_COUNT:   prdata = DATA_W'(cfg_r.subaperture_count);
      default:           prdata = '0;
    endcase
  end

  // Pixel accumulator.
  sct_front #(
    .MAX_WINDOW       (MAX_WINDOW),
    .MAX_SUBAPERTURES (MAX_SUBAPERTURES),
    .PIXEL_BITS       (PIXEL_BITS),
    .INDEX_BITS       (INDEX_BITS),
    .JOB_W            (JOB_W)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_stream),
    .cfg    (cfg_r),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_push_data)
  );

  // Request queue between accumulator and divider.
  sct_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .stat      (q_stat)
  );

  // Divider and output register.
  sct_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .PIXEL_BITS (PIXEL_BITS),
    .INDEX_BITS (INDEX_BITS),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_data (q_pop_data),
    .q_pop  (q_pop),
    .out_ch (out_result)
  );

  // The front end never writes into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
    else $error("window request pushed into a full queue");

  // The back end only fetches a request that is there.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
    else $error("request fetched from an empty queue");

  // Reset leaves an empty queue, so pixels are taken straight away.
  assert property (@(posedge clk) !rst_n |=> in_stream.ready)
    else $error("pixel input not ready after reset");

endmodule : subaperture_centroid_tracker

`default_nettype wire

### hw/rtl/sct_queue.sv
// ----------------------------------------------------------------------------
// sct_queue: short request queue
// Small register FIFO that decouples the pixel front end from the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_queue import sct_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output q_stat_t               stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

endmodule : sct_queue

`default_nettype wire

### hw/rtl/sct_front.sv
// ----------------------------------------------------------------------------
// sct_front: pixel accumulator front end
// Counts column and row, accumulates window and frame sums, and queues one
// centroid request at the last pixel of every window.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_front import sct_pkg::*; #(
  parameter int MAX_WINDOW       = MAX_WINDOW_DEF,
  parameter int MAX_SUBAPERTURES = MAX_SUBAPERTURES_DEF,
  parameter int PIXEL_BITS       = PIXEL_BITS_DEF,
  parameter int INDEX_BITS       = 10,
  parameter int JOB_W            = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sct_in_if.sink                 in_ch,
  input  wire cfg_t              cfg,
  input  wire q_stat_t           q_stat,
  output logic                   q_push,
  output logic [JOB_W-1:0]       q_data
);

  localparam int CNT_W  = $clog2(MAX_WINDOW);
  localparam int SUM_W  = PIXEL_BITS + 2 * CNT_W;
  localparam int WS_W   = SUM_W + CNT_W;
  localparam int PROD_W = PIXEL_BITS + CNT_W;
  localparam int SZ_L   = $clog2(MAX_WINDOW + 1);
  localparam int SZ_W   = (SZ_L > REG_SIZE_W) ? SZ_L : REG_SIZE_W;
  localparam int NL     = $clog2(MAX_SUBAPERTURES + 1);
  localparam int N_W    = (NL > REG_CNT_W) ? NL : REG_CNT_W;

  logic [CNT_W-1:0]      col_r, col_nxt;
  logic [CNT_W-1:0]      row_r, row_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [WS_W-1:0]       wcol_r, wcol_nxt;
  logic [WS_W-1:0]       wrow_r, wrow_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [FSUM_W-1:0]     ftot_r, ftot_nxt;
  logic [PIXEL_BITS-1:0] fpeak_r, fpeak_nxt;

  logic                  accept;
  logic [PIXEL_BITS-1:0] px;
  logic [SZ_W-1:0]       w_raw, h_raw, w_eff, h_eff;
  logic [N_W-1:0]        n_raw, n_eff, idx_inc;
  logic [SZ_W-1:0]       col_inc, row_inc;
  logic                  col_wrap, row_wrap, win_end, frame_last;
  logic [PROD_W-1:0]     prod_col, prod_row;
  logic [SUM_W-1:0]      sum_acc;
  logic [WS_W-1:0]       wcol_acc, wrow_acc;
  logic [FSUM_W-1:0]     ftot_acc;
  logic [PIXEL_BITS-1:0] fpeak_acc;

  // The front end only stalls when the request queue has no room.
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign px          = in_ch.pixel;

  // Effective window size and frame length: zero acts as one, excess clamps.
  assign w_raw = SZ_W'(cfg.window_width);
  assign h_raw = SZ_W'(cfg.window_height);
  assign n_raw = N_W'(cfg.subaperture_count);
  assign w_eff = (w_raw == '0) ? SZ_W'(1) :
                 (w_raw > SZ_W'(MAX_WINDOW)) ? SZ_W'(MAX_WINDOW) : w_raw;
  assign h_eff = (h_raw == '0) ? SZ_W'(1) :
                 (h_raw > SZ_W'(MAX_WINDOW)) ? SZ_W'(MAX_WINDOW) : h_raw;
  assign n_eff = (n_raw == '0) ? N_W'(1) :
                 (n_raw > N_W'(MAX_SUBAPERTURES)) ? N_W'(MAX_SUBAPERTURES) : n_raw;

  // Row and window end detection.
  assign col_inc    = SZ_W'(col_r) + 1'b1;
  assign row_inc    = SZ_W'(row_r) + 1'b1;
  assign col_wrap   = !(col_inc < w_eff);
  assign row_wrap   = !(row_inc < h_eff);
  assign win_end    = col_wrap && row_wrap;
  assign idx_inc    = N_W'(idx_r) + 1'b1;
  assign frame_last = (idx_inc >= n_eff);

  // Sums including the current pixel.
  assign prod_col  = PROD_W'(px) * PROD_W'(col_r);
  assign prod_row  = PROD_W'(px) * PROD_W'(row_r);
  assign sum_acc   = sum_r + SUM_W'(px);
  assign wcol_acc  = wcol_r + WS_W'(prod_col);
  assign wrow_acc  = wrow_r + WS_W'(prod_row);
  assign ftot_acc  = ftot_r + FSUM_W'(px);
  assign fpeak_acc = (px > fpeak_r) ? px : fpeak_r;

  // Request for the back end, taken at the window's last pixel.
  assign q_push = accept && win_end;
  assign q_data = {wcol_acc, wrow_acc, sum_acc, cfg.reference_x, cfg.reference_y,
                   idx_r, ftot_acc, fpeak_acc, frame_last};

  // Next state of the counters and accumulators.
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    sum_nxt   = sum_r;
    wcol_nxt  = wcol_r;
    wrow_nxt  = wrow_r;
    idx_nxt   = idx_r;
    ftot_nxt  = ftot_r;
    fpeak_nxt = fpeak_r;
    if (accept) begin
      sum_nxt   = sum_acc;
      wcol_nxt  = wcol_acc;
      wrow_nxt  = wrow_acc;
      ftot_nxt  = ftot_acc;
      fpeak_nxt = fpeak_acc;
      if (!col_wrap) begin
        col_nxt = col_r + 1'b1;
      end else begin
        col_nxt = '0;
        if (!row_wrap) begin
          row_nxt = row_r + 1'b1;
        end else begin
          row_nxt  = '0;
          sum_nxt  = '0;
          wcol_nxt = '0;
          wrow_nxt = '0;
          if (frame_last) begin
            idx_nxt   = '0;
            ftot_nxt  = '0;
            fpeak_nxt = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      sum_r   <= '0;
      wcol_r  <= '0;
      wrow_r  <= '0;
      idx_r   <= '0;
      ftot_r  <= '0;
      fpeak_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      sum_r   <= sum_nxt;
      wcol_r  <= wcol_nxt;
      wrow_r  <= wrow_nxt;
      idx_r   <= idx_nxt;
      ftot_r  <= ftot_nxt;
      fpeak_r <= fpeak_nxt;
    end
  end

endmodule : sct_front

`default_nettype wire

### hw/rtl/sct_back.sv
// ----------------------------------------------------------------------------
// sct_back: centroid divider back end
// Takes one request from the queue, runs two restoring dividers side by side
// (one quotient bit per cycle) and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_back import sct_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int INDEX_BITS = 10,
  parameter int JOB_W      = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire q_stat_t          q_stat,
  input  wire logic [JOB_W-1:0] q_data,
  output logic                  q_pop,
  sct_out_if.source             out_ch
);

  localparam int CNT_W   = $clog2(MAX_WINDOW);
  localparam int SUM_W   = PIXEL_BITS + 2 * CNT_W;
  localparam int WS_W    = SUM_W + CNT_W;
  localparam int QW      = CNT_W + FRAC_BITS;
  localparam int REF_W   = REG_SIZE_W + FRAC_BITS;
  localparam int CW      = ((QW > REF_W) ? QW : REF_W) + 2;
  localparam int STEP_W  = $clog2(QW + 1);
  localparam int COG_MAX = (1 << (COG_W - 1)) - 1;

  // Request fields.
  logic [WS_W-1:0]       j_wcol, j_wrow;
  logic [SUM_W-1:0]      j_sum;
  logic [REG_SIZE_W-1:0] j_refx, j_refy;
  logic [INDEX_BITS-1:0] j_idx;
  logic [FSUM_W-1:0]     j_fsum;
  logic [PIXEL_BITS-1:0] j_fmax;
  logic                  j_last;

  back_state_t           state_r, state_nxt;
  logic [STEP_W-1:0]     step_r;
  logic [SUM_W-1:0]      den_r;
  logic [SUM_W-1:0]      rem_x_r, rem_y_r;
  logic [QW-1:0]         dvd_x_r, dvd_y_r;
  logic [REG_SIZE_W-1:0] refx_r, refy_r;
  logic [INDEX_BITS-1:0] idx_r;
  logic [FSUM_W-1:0]     fsum_r;
  logic [PIXEL_BITS-1:0] fmax_r;
  logic                  last_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [COG_W-1:0]      cog_x_r, cog_y_r;
  logic [INDEX_BITS-1:0] out_idx_r;
  logic [FSUM_W-1:0]     out_fsum_r;
  logic [PIXEL_BITS-1:0] out_fmax_r;
  logic                  out_done_r;

  logic                  load_out;
  logic [SUM_W+QW-1:0]   step_x, step_y;
  logic                  den_zero;

  assign {j_wcol, j_wrow, j_sum, j_refx, j_refy, j_idx, j_fsum, j_fmax, j_last} = q_data;

  // One restoring division step: returns the new remainder and the dividend
  // shifted left with the quotient bit brought in at the bottom.
  function automatic logic [SUM_W+QW-1:0] div_step(input logic [SUM_W-1:0] rem,
                                                   input logic [QW-1:0]    dvd,
                                                   input logic [SUM_W-1:0] den);
    logic [SUM_W:0] trial;
    logic [SUM_W:0] dext;
    trial = {rem, dvd[QW-1]};
    dext  = {1'b0, den};
    if (trial >= dext) begin
      return {SUM_W'(trial - dext), dvd[QW-2:0], 1'b1};
    end else begin
      return {SUM_W'(trial), dvd[QW-2:0], 1'b0};
    end
  endfunction

  // Reference minus quotient, truncated toward zero and saturated.
  function automatic logic [COG_W-1:0] cog_calc(input logic [REG_SIZE_W-1:0] refv,
                                                input logic [QW-1:0]         quo,
                                                input logic                  rem_nz,
                                                input logic                  zero);
    logic signed [CW-1:0] rscaled;
    logic signed [CW-1:0] qext;
    logic signed [CW-1:0] diff;
    logic signed [CW-1:0] res;
    rscaled = $signed(CW'({refv, {FRAC_BITS{1'b0}}}));
    qext    = $signed(CW'(quo));
    diff    = rscaled - qext;
    // A fractional part pulls a positive result down toward zero.
    res     = (rem_nz && (diff > $signed(CW'(0)))) ? diff - $signed(CW'(1)) : diff;
    if (zero) begin
      return '0;
    end else if (res > $signed(CW'(COG_MAX))) begin
      return COG_W'(COG_MAX);
    end else if (res < -$signed(CW'(COG_MAX)) - $signed(CW'(1))) begin
      return {1'b1, {(COG_W-1){1'b0}}};
    end else begin
      return COG_W'(res);
    end
  endfunction

  assign step_x   = div_step(rem_x_r, dvd_x_r, den_r);
  assign step_y   = div_step(rem_y_r, dvd_y_r, den_r);
  assign den_zero = (den_r == '0);

  // Sequencer: fetch a request, divide, hand over to the output register.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step_r == STEP_W'(1)) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Divider working registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      den_r   <= j_sum;
      rem_x_r <= j_wcol[WS_W-1:CNT_W];
      rem_y_r <= j_wrow[WS_W-1:CNT_W];
      dvd_x_r <= {j_wcol[CNT_W-1:0], {FRAC_BITS{1'b0}}};
      dvd_y_r <= {j_wrow[CNT_W-1:0], {FRAC_BITS{1'b0}}};
      step_r  <= STEP_W'(QW);
      refx_r  <= j_refx;
      refy_r  <= j_refy;
      idx_r   <= j_idx;
      fsum_r  <= j_fsum;
      fmax_r  <= j_fmax;
      last_r  <= j_last;
    end else if (state_r == BK_DIV) begin
      {rem_x_r, dvd_x_r} <= step_x;
      {rem_y_r, dvd_y_r} <= step_y;
      step_r             <= step_r - 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      cog_x_r    <= cog_calc(refx_r, dvd_x_r, rem_x_r != '0, den_zero);
      cog_y_r    <= cog_calc(refy_r, dvd_y_r, rem_y_r != '0, den_zero);
      out_idx_r  <= idx_r;
      out_fsum_r <= fsum_r;
      out_fmax_r <= fmax_r;
      out_done_r <= last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cog_x        = $signed(cog_x_r);
  assign out_ch.cog_y        = $signed(cog_y_r);
  assign out_ch.window_index = out_idx_r;
  assign out_ch.frame_sum    = out_fsum_r;
  assign out_ch.frame_max    = out_fmax_r;
  assign out_ch.frame_done   = out_done_r;

endmodule : sct_back

`default_nettype wire

### tb/sv/sct_centroid_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sct_centroid_checker: result checker for the subaperture centroid tracker
// Watches the pixel, result and configuration ports. It keeps its own copy of
// the window accumulators, the frame statistics and the registers, works out
// the centroid request that each window end must give, and compares every
// accepted result request, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------

module sct_centroid_checker
  import sct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  sct_in_if                 pix_bus,
  sct_out_if                res_bus,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int unsigned       results_due,
  output int unsigned       mismatches
);

  // One centroid result as it leaves the block.
  typedef struct packed {
    logic signed [COG_W-1:0] cog_x;
    logic signed [COG_W-1:0] cog_y;
    logic [9:0]              window_index;
    logic [FSUM_W-1:0]       frame_sum;
    logic [15:0]             frame_max;
    logic                    frame_done;
  } centroid_t;

  // Register copy, as last written over the configuration port.
  cfg_t cfg;

  // Window accumulators and frame statistics.
  logic [5:0]        col_pos;
  logic [5:0]        row_pos;
  logic [27:0]       win_sum;
  logic [33:0]       win_wcol;
  logic [33:0]       win_wrow;
  logic [9:0]        win_idx;
  logic [FSUM_W-1:0] frm_sum;
  logic [15:0]       frm_peak;

  centroid_t   due_centroids[$];
  int unsigned fails = 0;

  // A size register of zero acts as one, and anything above the limit as the limit.
  function automatic int unsigned clamp_count(int unsigned value, int unsigned limit);
    if (value == 0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  // Reference minus weighted mean, 8 fraction bits, truncated toward zero.
  function automatic logic signed [COG_W-1:0] win_offset(logic [6:0] anchor,
                                                          logic [33:0] wsum,
                                                          logic [27:0] isum);
    longint num;
    longint quot;
    if (isum == 0) return '0;
    num  = longint'(anchor) * 256 * longint'(isum) - longint'(wsum) * 256;
    quot = num / longint'(isum);
    if (quot > 32767) quot = 32767;
    if (quot < -32768) quot = -32768;
    return quot[COG_W-1:0];
  endfunction

  // Takes one pixel into the accumulators; returns 1 with the result at a window end.
  function automatic bit absorb_pixel(input logic [15:0] px, output centroid_t res);
    int unsigned w;
    int unsigned h;
    int unsigned n;
    bit          closes_frame;
    w   = clamp_count(cfg.window_width, MAX_WINDOW_DEF);
    h   = clamp_count(cfg.window_height, MAX_WINDOW_DEF);
    n   = clamp_count(cfg.subaperture_count, MAX_SUBAPERTURES_DEF);
    res = '0;

    win_sum  += px;
    win_wcol += px * col_pos;
    win_wrow += px * row_pos;
    frm_sum  += px;
    if (px > frm_peak) frm_peak = px;

    // Column and row advance; a bound lowered mid-window ends the row at once.
    if (col_pos + 1 < w) begin
      col_pos++;
      return 0;
    end
    col_pos = '0;
    if (row_pos + 1 < h) begin
      row_pos++;
      return 0;
    end
    row_pos = '0;

    closes_frame     = (win_idx + 1 >= n);
    res.cog_x        = win_offset(cfg.reference_x, win_wcol, win_sum);
    res.cog_y        = win_offset(cfg.reference_y, win_wrow, win_sum);
    res.window_index = win_idx;
    res.frame_sum    = frm_sum;
    res.frame_max    = frm_peak;
    res.frame_done   = closes_frame;

    win_sum  = '0;
    win_wcol = '0;
    win_wrow = '0;
    if (closes_frame) begin
      win_idx  = '0;
      frm_sum  = '0;
      frm_peak = '0;
    end else begin
      win_idx++;
    end
    return 1;
  endfunction

  task automatic check_field(input string field, input logic signed [40:0] want,
                             input logic signed [40:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endtask

  // Everything is sampled at the rising edge, before the block's outputs move.
  always @(posedge clk) begin : track
    centroid_t want;
    centroid_t got;
    if (!rst_n) begin
      cfg.window_width      = 7'd8;
      cfg.window_height     = 7'd8;
      cfg.reference_x       = 7'd8;
      cfg.reference_y       = 7'd8;
      cfg.subaperture_count = 11'd1;
      col_pos  = '0;
      row_pos  = '0;
      win_sum  = '0;
      win_wcol = '0;
      win_wrow = '0;
      win_idx  = '0;
      frm_sum  = '0;
      frm_peak = '0;
      due_centroids.delete();
    end else begin
      // Register writes take effect for the next pixel.
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_WINDOW_WIDTH:  cfg.window_width      = pwdata[REG_SIZE_W-1:0];
          REG_WINDOW_HEIGHT: cfg.window_height     = pwdata[REG_SIZE_W-1:0];
          REG_REFERENCE_X:   cfg.reference_x       = pwdata[REG_SIZE_W-1:0];
          REG_REFERENCE_Y:   cfg.reference_y       = pwdata[REG_SIZE_W-1:0];
          REG_SUBAP_COUNT:   cfg.subaperture_count = pwdata[REG_CNT_W-1:0];
          default: ;
        endcase
      end

      if (pix_bus.valid && pix_bus.ready) begin
        if (absorb_pixel(pix_bus.pixel, want)) due_centroids.push_back(want);
      end

      // Each result request is held against the oldest window end still due.
      if (res_bus.valid && res_bus.ready) begin
        got.cog_x        = res_bus.cog_x;
        got.cog_y        = res_bus.cog_y;
        got.window_index = res_bus.window_index;
        got.frame_sum    = res_bus.frame_sum;
        got.frame_max    = res_bus.frame_max;
        got.frame_done   = res_bus.frame_done;
        if (due_centroids.size() == 0) begin
          $error("centroid result request with no window end pending");
          fails++;
        end else begin
          want = due_centroids.pop_front();
          check_field("cog_x", want.cog_x, got.cog_x);
          check_field("cog_y", want.cog_y, got.cog_y);
          check_field("window_index", want.window_index, got.window_index);
          check_field("frame_sum", want.frame_sum, got.frame_sum);
          check_field("frame_max", want.frame_max, got.frame_max);
          check_field("frame_done", want.frame_done, got.frame_done);
        end
      end
    end
    results_due <= due_centroids.size();
    mismatches  <= fails;
  end

endmodule : sct_centroid_checker

### tb/sv/tb_subaperture_centroid_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_subaperture_centroid_tracker: testbench top for the centroid tracker
// Streams tracker windows of many shapes and intensity patterns into the
// block, reprogramming the window registers between phases, while both sides
// of the stream pause at random and the result side once holds off for long
// enough to back the block up. The checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_subaperture_centroid_tracker;
  import sct_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_PIXELS = 1000;
  localparam int WIDE_ROWS     = 8;

  // Intensity patterns for one window.
  typedef enum int {
    PX_NOISE,
    PX_DARK,
    PX_DIM,
    PX_SPOT,
    PX_SATURATED
  } px_style_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int unsigned results_due;
  int unsigned mismatches;
  int unsigned hold_requests;
  int unsigned quiet_cycles;
  int unsigned random_sent;
  bit          sender_gaps;

  sct_in_if  pix_bus ();
  sct_out_if res_bus ();

  subaperture_centroid_tracker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (pix_bus),
    .out_result (res_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  sct_centroid_checker u_centroid_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_bus     (pix_bus),
    .res_bus     (res_bus),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .results_due (results_due),
    .mismatches  (mismatches)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Ends the run when neither stream moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_subaperture_centroid_tracker failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls in stretches, and one long hold-off on request.
  initial begin : result_sink
    int unsigned stall;
    int unsigned holds_served;
    bit          stalls_on;
    holds_served = 0;
    stalls_on    = 1'b1;
    res_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_requests != holds_served) begin
        holds_served++;
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 15) == 0) stalls_on = !stalls_on;
      stall = stalls_on ? $urandom_range(0, 10) : 0;
      if (stall != 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
    end
  end

  // Offers one pixel request after a random gap and waits until it is taken.
  task automatic send_pixel(input logic [15:0] value);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) sender_gaps = !sender_gaps;
    gap = sender_gaps ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.pixel <= value;
    do @(posedge clk); while (!pix_bus.ready);
  endtask

  // Setup and access phase, then the bus goes idle before the next write.
  task automatic write_reg(input cfg_reg_t index, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_window(input logic [6:0] w, input logic [6:0] h,
                                input logic [6:0] rx, input logic [6:0] ry,
                                input logic [10:0] count);
    write_reg(REG_WINDOW_WIDTH, DATA_W'(w));
    write_reg(REG_WINDOW_HEIGHT, DATA_W'(h));
    write_reg(REG_REFERENCE_X, DATA_W'(rx));
    write_reg(REG_REFERENCE_Y, DATA_W'(ry));
    write_reg(REG_SUBAP_COUNT, DATA_W'(count));
  endtask

  // Waits until every window end has reported, then lets a partial window settle.
  task automatic drain();
    pix_bus.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] draw_pixel(px_style_t style);
    case (style)
      PX_DARK:      return 16'h0000;
      PX_DIM:       return 16'($urandom_range(0, 15));
      PX_SPOT:      return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h0000;
      PX_SATURATED: return 16'hFFFF;
      default:      return 16'($urandom);
    endcase
  endfunction

  // Size register value: mostly small, sometimes zero or large, at times beyond the limit.
  function automatic logic [6:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'($urandom_range(9, 127));
      default: return 7'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [10:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return 11'd0;
      1:       return 11'($urandom_range(1025, 2047));
      default: return 11'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic int unsigned eff_dim(logic [6:0] value);
    if (value == 0) return 1;
    if (value > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
    return value;
  endfunction

  // Whole windows with a pattern each, then an optional partial window.
  task automatic send_windows(input int unsigned area, input int unsigned windows,
                              input int unsigned tail);
    px_style_t style;
    for (int unsigned k = 0; k < windows; k++) begin
      case ($urandom_range(0, 9))
        0:       style = PX_DARK;
        1:       style = PX_SATURATED;
        2, 3:    style = PX_DIM;
        4, 5:    style = PX_SPOT;
        default: style = PX_NOISE;
      endcase
      repeat (area) send_pixel(draw_pixel(style));
    end
    repeat (tail) send_pixel(draw_pixel(PX_NOISE));
    random_sent += area * windows + tail;
  endtask

  initial begin : stimulus
    logic [15:0] column_px[8];
    logic [15:0] partial_px[4];
    logic [6:0]  w_raw;
    logic [6:0]  h_raw;
    int unsigned area;
    int unsigned tail;

    column_px  = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                   16'h0001, 16'h8000, 16'h7FFF, 16'h00FF};
    partial_px = '{16'h0100, 16'h0000, 16'h0FF0, 16'h1234};
    pix_bus.valid <= 1'b0;
    pix_bus.pixel <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    hold_requests <= 0;
    rst_n         <= 1'b0;
    random_sent   = 0;
    sender_gaps   = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One-pixel-wide column over the reset height, references and count.
    write_reg(REG_WINDOW_WIDTH, DATA_W'(1));
    foreach (column_px[i]) send_pixel(column_px[i]);
    drain();

    // Zero sizes and count act as one: an empty window, then a full one.
    program_window(7'd0, 7'd0, 7'd0, 7'd127, 11'd0);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    drain();

    // Two-window frame; the second window is cut short by a narrower width.
    program_window(7'd3, 7'd2, 7'd64, 7'd64, 11'd2);
    repeat (6) send_pixel(16'hFFFF);
    foreach (partial_px[i]) send_pixel(partial_px[i]);
    drain();
    write_reg(REG_WINDOW_WIDTH, DATA_W'(1));
    send_pixel(16'h4321);
    drain();

    // Single-pixel windows under an oversized count while results back up.
    program_window(7'd1, 7'd1, 7'($urandom), 7'($urandom), 11'h7FF);
    hold_requests <= hold_requests + 1;
    repeat (200) send_pixel(draw_pixel(PX_NOISE));
    random_sent += 200;
    drain();

    // Random phases: mostly whole windows, some ending mid-window.
    while (random_sent < RANDOM_PIXELS) begin
      w_raw = pick_size();
      h_raw = pick_size();
      if (eff_dim(w_raw) * eff_dim(h_raw) > 128) begin
        if (eff_dim(w_raw) >= eff_dim(h_raw)) h_raw = 7'($urandom_range(1, 2));
        else w_raw = 7'($urandom_range(1, 2));
      end
      program_window(w_raw, h_raw, 7'($urandom), 7'($urandom), pick_count());
      area = eff_dim(w_raw) * eff_dim(h_raw);
      tail = (area > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, area - 1) : 0;
      send_windows(area, $urandom_range(1, 4), tail);
      drain();
    end

    // Widest window at full scale drives the column sums to their largest.
    program_window(7'd127, 7'(WIDE_ROWS), 7'd0, 7'd127, 11'd1);
    repeat (MAX_WINDOW_DEF * WIDE_ROWS) send_pixel(16'hFFFF);
    drain();

    if (mismatches == 0) begin
      $display("tb_subaperture_centroid_tracker passed");
    end else begin
      $display("tb_subaperture_centroid_tracker failed");
    end
    $finish;
  end

endmodule : tb_subaperture_centroid_tracker
